// ===== rtl/core/tscd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscd_pkg
// Shared types, codes and helpers of the timestamped sample cluster decoder.
// ----------------------------------------------------------------------------
package tscd_pkg;

	localparam int EVENT_W       = 16;
	localparam int EVENTS        = 7;
	localparam int COUNT_W       = 18;
	localparam int IN_TDATA_W    = 128;
	localparam int OUT_TDATA_W   = 40;
	localparam int QUEUE_DEPTH   = 2;
	localparam int CHUNK_W       = 15;
	localparam int POS_W         = 9;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_SAMPLE_MODE      = 2'd0;
	localparam logic [1:0] REG_TRIGGER_ENABLE   = 2'd1;
	localparam logic [1:0] REG_TRIGGER_CHUNK    = 2'd2;
	localparam logic [1:0] REG_TRIGGER_POSITION = 2'd3;

	// Sample modes: 16 probes, 8 probes; everything else decodes as 4 probes.
	localparam logic [1:0] MODE_16 = 2'd0;
	localparam logic [1:0] MODE_8  = 2'd1;

	// Result kinds on tuser.
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_MARKER = 1'b1;

	typedef struct packed {
		logic [1:0]         mode;
		logic               trig_en;
		logic [CHUNK_W-1:0] trig_chunk;
		logic [POS_W-1:0]   trig_pos;
	} cfg_t;

	// One classified cluster, as handed from the front to the back.
	typedef struct packed {
		logic [1:0]                     lg;
		logic                           pad_valid;
		logic [COUNT_W-1:0]             pad_len;
		logic [EVENT_W-1:0]             pad_value;
		logic                           trig_valid;
		logic [2:0]                     trig_before;
		logic [EVENTS-1:0][EVENT_W-1:0] events;
	} entry_t;

	// log2 of the samples per event.
	function automatic logic [1:0] spe_log2(input logic [1:0] mode);
		logic [1:0] lg;
		case (mode)
			MODE_16: lg = 2'd0;
			MODE_8:  lg = 2'd1;
			default: lg = 2'd2;
		endcase
		return lg;
	endfunction

	// Picks sample k out of an interleaved event word.
	function automatic logic [EVENT_W-1:0] deinterleave(input logic [EVENT_W-1:0] ev,
		input logic [1:0] lg, input logic [1:0] k);
		logic [EVENT_W-1:0] s;
		s = '0;
		case (lg)
			2'd0: s = ev;
			2'd1: for (int l = 0; l < 8; l++) s[l] = ev[4'(2 * l) + 4'(k)];
			default: for (int l = 0; l < 4; l++) s[l] = ev[4'(4 * l) + 4'(k)];
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/core/tscd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscd_front
// Accepts clusters, works out the pad run and the trigger marker place, and
// keeps the timestamp, last sample and chunk counters.
// ----------------------------------------------------------------------------
module tscd_front import tscd_pkg::*; #(
	parameter int CLUSTERS_PER_CHUNK = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  logic                  full,
	output logic                  push,
	output entry_t                entry
);

	localparam int CW   = (CLUSTERS_PER_CHUNK > 1) ? $clog2(CLUSTERS_PER_CHUNK) : 1;
	localparam int CMPW = (CW > 7) ? CW : 7;

	logic [EVENT_W-1:0]             prev_ts_q;
	logic [EVENT_W-1:0]             prev_sample_q;
	logic [CW-1:0]                  cluster_q;
	logic [CHUNK_W-1:0]             chunk_q;
	logic                           first_q;

	logic [EVENT_W-1:0]             ts;
	logic [EVENTS-1:0][EVENT_W-1:0] events;
	logic [1:0]                     lg;
	logic [EVENT_W-1:0]             gap;
	logic [COUNT_W-1:0]             pad_base;
	logic [POS_W-1:0]               pos_adj;
	logic [18:0]                    prod;
	logic [6:0]                     quo;
	logic [POS_W-1:0]               quo7;
	logic [2:0]                     rem;
	logic [CMPW-1:0]                quo_x;
	logic [CMPW-1:0]                cluster_x;

	assign ts = s_tdata[EVENT_W-1:0];
	always_comb begin
		for (int j = 0; j < EVENTS; j++) begin
			events[j] = s_tdata[EVENT_W*(j+1) +: EVENT_W];
		end
	end

	assign s_tready = !full;
	assign push     = s_tvalid && s_tready;
	assign lg       = spe_log2(cfg.mode);

	// Pad run covers the timestamp gap beyond one cluster, in samples.
	assign gap      = ts - prev_ts_q;
	assign pad_base = {2'b00, gap - 16'(EVENTS)};

	// Trigger place: position / 7 by reciprocal (exact for 9-bit values).
	always_comb begin
		if (cfg.mode == MODE_16) begin
			pos_adj = (cfg.trig_pos >= 9'(EVENTS)) ? cfg.trig_pos - 9'(EVENTS) : '0;
		end else begin
			pos_adj = cfg.trig_pos;
		end
	end
	assign prod      = 19'(pos_adj) * 19'd293;
	assign quo       = prod[17:11];
	assign quo7      = 9'({2'b00, quo} * 9'd7);
	assign rem       = 3'(pos_adj - quo7);
	assign quo_x     = CMPW'(quo);
	assign cluster_x = CMPW'(cluster_q);

	always_comb begin
		entry.lg          = lg;
		entry.pad_valid   = !first_q && (gap > 16'(EVENTS));
		entry.pad_len     = pad_base << lg;
		entry.pad_value   = prev_sample_q;
		entry.trig_valid  = cfg.trig_en && (chunk_q == cfg.trig_chunk) && (quo_x == cluster_x);
		if (cfg.mode == MODE_16) begin
			entry.trig_before = rem;
		end else begin
			entry.trig_before = (rem >= 3'd3) ? rem - 3'd3 : 3'd0;
		end
		entry.events      = events;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ts_q     <= '0;
			prev_sample_q <= '0;
			cluster_q     <= '0;
			chunk_q       <= '0;
			first_q       <= 1'b1;
		end else if (push) begin
			prev_ts_q     <= ts;
			prev_sample_q <= deinterleave(events[EVENTS-1], lg, ~(2'b11 << lg));
			first_q       <= 1'b0;
			if (cluster_q == CW'(CLUSTERS_PER_CHUNK - 1)) begin
				cluster_q <= '0;
				chunk_q   <= chunk_q + 1'b1;
			end else begin
				cluster_q <= cluster_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/tscd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscd_queue
// Short queue of classified clusters between the front and the back.
// ----------------------------------------------------------------------------
module tscd_queue import tscd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	entry_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full       = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/tscd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscd_back
// Walks one classified cluster: pad run, decoded samples and the trigger
// marker, one result per cycle into the output register while it has room.
// ----------------------------------------------------------------------------
module tscd_back import tscd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  entry_t                 head,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);

	logic                   pad_done_q;
	logic                   mark_done_q;
	logic [4:0]             si_q;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                   m_tuser_q;
	logic                   m_tlast_q;

	logic                   advance;
	logic                   emit_pad;
	logic                   emit_mark;
	logic                   last_sample;
	logic [4:0]             nsamp_m1;
	logic [2:0]             ev_sel;
	logic [1:0]             sub;
	logic [EVENT_W-1:0]     sample;

	assign advance     = head_valid && (!m_tvalid_q || m_tready);
	assign emit_pad    = head.pad_valid && !pad_done_q;
	assign emit_mark   = head.trig_valid && !mark_done_q && (si_q == {2'b00, head.trig_before});
	assign nsamp_m1    = 5'((5'd7 << head.lg) - 5'd1);
	assign last_sample = (si_q == nsamp_m1);
	assign ev_sel      = 3'(si_q >> head.lg);
	assign sub         = si_q[1:0] & ~(2'b11 << head.lg);
	assign sample      = deinterleave(head.events[ev_sel], head.lg, sub);
	assign pop         = advance && !emit_pad && !emit_mark && last_sample;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_done_q  <= 1'b0;
			mark_done_q <= 1'b0;
			si_q        <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (m_tready && !advance) begin
				m_tvalid_q <= 1'b0;
			end
			if (advance) begin
				m_tvalid_q <= 1'b1;
				if (emit_pad) begin
					pad_done_q <= 1'b1;
				end else if (emit_mark) begin
					mark_done_q <= 1'b1;
				end else if (last_sample) begin
					pad_done_q  <= 1'b0;
					mark_done_q <= 1'b0;
					si_q        <= '0;
				end else begin
					si_q <= si_q + 1'b1;
				end
			end
		end
	end

	// Result payload, loaded whenever a new result enters the output register.
	always_ff @(posedge clk) begin
		if (advance) begin
			if (emit_pad) begin
				m_tuser_q <= KIND_SAMPLE;
				m_tlast_q <= 1'b0;
				m_tdata_q <= {6'd0, head.pad_len, head.pad_value};
			end else if (emit_mark) begin
				m_tuser_q <= KIND_MARKER;
				m_tlast_q <= 1'b0;
				m_tdata_q <= '0;
			end else begin
				m_tuser_q <= KIND_SAMPLE;
				m_tlast_q <= last_sample;
				m_tdata_q <= {6'd0, 18'd1, sample};
			end
		end
	end

endmodule

// ===== rtl/core/timestamped_sample_cluster_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_sample_cluster_decoder_unit
// Decodes capture clusters into pad runs, samples and trigger markers.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake             Payload
//  s_*       in   s_tvalid / s_tready   cluster: timestamp and seven events
//  m_*       out  m_tvalid / m_tready   result: sample, run or marker
//  cfg_*     in   cfg_valid / cfg_ready register index and write data
//
// The result side gives one result per cycle while the receiver takes it;
// a cluster yields 7, 14 or 28 samples by sample mode, plus one result for
// a pad run and one for a marker. The back sequencer and its output register
// set that rate; the front takes a new request while the two-entry queue has
// room, and a cluster's results pass from the queue into the output register.
// Reset is asynchronous and clears all control state; no clearing pass.
// Either side may stall at any time without loss.
// ----------------------------------------------------------------------------
module timestamped_sample_cluster_decoder_unit import tscd_pkg::*; #(
	parameter int CLUSTERS_PER_CHUNK = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// timestamp, event_zero .. event_six, 16 bits each
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// sample_value [15:0], repeat_count [33:16], zeros above
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// kind
	output logic                   m_tuser,
	output logic                   m_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [CHUNK_W-1:0]     cfg_data
);

	cfg_t   cfg_q;
	logic   push;
	logic   full;
	logic   pop;
	logic   head_valid;
	entry_t wr_entry;
	entry_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SAMPLE_MODE:      cfg_q.mode       <= cfg_data[1:0];
				REG_TRIGGER_ENABLE:   cfg_q.trig_en    <= cfg_data[0];
				REG_TRIGGER_CHUNK:    cfg_q.trig_chunk <= cfg_data;
				REG_TRIGGER_POSITION: cfg_q.trig_pos   <= cfg_data[POS_W-1:0];
			endcase
		end
	end

	tscd_front #(
		.CLUSTERS_PER_CHUNK(CLUSTERS_PER_CHUNK)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.full     (full),
		.push     (push),
		.entry    (wr_entry)
	);

	tscd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_entry   (wr_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tscd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// ===== rtl/core/tscd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscd_checker
// Port-level checks on the result stream of the cluster decoder.
// ----------------------------------------------------------------------------
module tscd_checker import tscd_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser,
	input logic                   m_tlast
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// A marker carries no sample, no count, and is never the end of a cluster.
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_MARKER) |-> (m_tdata == '0) && !m_tlast)
		else $error("malformed trigger marker");

	// Every cluster ends on a single decoded sample.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tuser == KIND_SAMPLE) && (m_tdata[33:16] == 18'd1))
		else $error("cluster does not end on a decoded sample");

	// Samples and pad runs always repeat at least once.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_SAMPLE) |-> (m_tdata[33:16] != 18'd0)
			&& (m_tdata[39:34] == 6'd0))
		else $error("sample result with zero repeat count");

endmodule

bind timestamped_sample_cluster_decoder_unit tscd_checker u_tscd_checker (.*);

// ===== verif/timestamped_sample_cluster_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_sample_cluster_decoder_unit_tb
// Drives capture clusters through the decoder under every sample mode and a
// range of trigger settings. A scoreboard predicts the pad runs, samples and
// markers of each accepted cluster and checks the result stream in order,
// while the sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module timestamped_sample_cluster_decoder_unit_tb;
	import tscd_pkg::*;

	localparam int CLUSTERS_PER_CHUNK = 64;
	localparam int CYCLE_LIMIT        = 600000;
	localparam int SETTLE_CYCLES      = 8;
	localparam int MAX_REPORTS        = 40;

	// Receiver stall styles.
	localparam int READY_ALWAYS = 0;
	localparam int READY_COIN   = 1;
	localparam int READY_SPARSE = 2;
	localparam int READY_MOSTLY = 3;

	typedef struct packed {
		logic               kind;
		logic [EVENT_W-1:0] value;
		logic [COUNT_W-1:0] count;
		logic               last;
	} decoded_t;

	class cluster_scoreboard;
		logic [1:0]         mode;
		logic               trig_en;
		logic [CHUNK_W-1:0] trig_chunk;
		logic [POS_W-1:0]   trig_pos;
		logic [15:0]        prev_ts;
		logic [15:0]        prev_sample;
		int                 cluster_idx;
		logic [CHUNK_W-1:0] chunk_idx;
		bit                 first_pending;
		decoded_t           expected_results[$];
		int                 errors;
		int                 reports;

		function new();
			mode = '0;
			trig_en = 1'b0;
			trig_chunk = '0;
			trig_pos = '0;
			prev_ts = '0;
			prev_sample = '0;
			cluster_idx = 0;
			chunk_idx = '0;
			first_pending = 1'b1;
			errors = 0;
			reports = 0;
		endfunction

		function void write_reg(input logic [1:0] idx, input logic [CHUNK_W-1:0] data);
			case (idx)
				REG_SAMPLE_MODE:      mode = data[1:0];
				REG_TRIGGER_ENABLE:   trig_en = data[0];
				REG_TRIGGER_CHUNK:    trig_chunk = data;
				REG_TRIGGER_POSITION: trig_pos = data[POS_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Works out every result that one accepted cluster request causes.
		function void note_cluster(input logic [IN_TDATA_W-1:0] d);
			int spe;
			int probes;
			int marker_slot;
			int pos;
			int off;
			int n;
			logic [15:0] ts;
			logic [15:0] gap;
			logic [15:0] ev;
			logic [15:0] smp;
			decoded_t r;
			spe = (mode == MODE_16) ? 1 : (mode == MODE_8) ? 2 : 4;
			probes = 16 / spe;
			ts = d[15:0];
			gap = ts - prev_ts;
			prev_ts = ts;
			if (first_pending) begin
				first_pending = 1'b0;
			end else if (gap > 16'd7) begin
				r.kind = KIND_SAMPLE;
				r.value = prev_sample;
				r.count = COUNT_W'(int'(gap) * spe - 7 * spe);
				r.last = 1'b0;
				expected_results.push_back(r);
			end
			marker_slot = -1;
			if (trig_en && chunk_idx == trig_chunk) begin
				pos = int'(trig_pos);
				off = 0;
				// The 16-probe mode counts its position one cluster late.
				if (mode == MODE_16)
					pos = (pos >= 7) ? pos - 7 : 0;
				else
					off = 3;
				if (pos / 7 == cluster_idx)
					marker_slot = (pos % 7 - off < 0) ? 0 : pos % 7 - off;
			end
			n = 0;
			smp = '0;
			for (int j = 0; j < EVENTS; j++) begin
				ev = d[16 * (j + 1) +: 16];
				for (int k = 0; k < spe; k++) begin
					smp = '0;
					for (int l = 0; l < probes; l++)
						smp[l] = ev[(l * spe + k) % 16];
					if (n == marker_slot) begin
						r.kind = KIND_MARKER;
						r.value = '0;
						r.count = '0;
						r.last = 1'b0;
						expected_results.push_back(r);
					end
					r.kind = KIND_SAMPLE;
					r.value = smp;
					r.count = COUNT_W'(1);
					r.last = 1'b0;
					expected_results.push_back(r);
					n++;
				end
			end
			prev_sample = smp;
			expected_results[expected_results.size() - 1].last = 1'b1;
			cluster_idx++;
			if (cluster_idx >= CLUSTERS_PER_CHUNK) begin
				cluster_idx = 0;
				chunk_idx = chunk_idx + 1'b1;
			end
		endfunction

		function void check_result(input logic [OUT_TDATA_W-1:0] data, input logic kind,
			input logic last);
			decoded_t got;
			decoded_t want;
			got.kind = kind;
			got.value = data[15:0];
			got.count = data[33:16];
			got.last = last;
			if (expected_results.size() == 0) begin
				errors++;
				if (reports++ < MAX_REPORTS)
					$display("%0t: unexpected result kind %0d value %h count %0d last %0d",
						$time, got.kind, got.value, got.count, got.last);
				return;
			end
			want = expected_results.pop_front();
			if (got.kind !== want.kind || got.value !== want.value ||
				got.count !== want.count || got.last !== want.last) begin
				errors++;
				if (reports++ < MAX_REPORTS)
					$display("%0t: mismatch expected kind %0d value %h count %0d last %0d, actual kind %0d value %h count %0d last %0d",
						$time, want.kind, want.value, want.count, want.last,
						got.kind, got.value, got.count, got.last);
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [1:0]             cfg_index = '0;
	logic [CHUNK_W-1:0]     cfg_data = '0;

	cluster_scoreboard board = new();
	int cycle_count = 0;
	int burst_left = 1;
	int stall_style = READY_ALWAYS;
	int stall_left = 0;
	int beat = 0;

	timestamped_sample_cluster_decoder_unit #(
		.CLUSTERS_PER_CHUNK(CLUSTERS_PER_CHUNK)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Accepted requests are noted before results are checked, so a result in
	// the same cycle as its own cluster would still find its expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.write_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				board.note_cluster(s_tdata);
			if (m_tvalid && m_tready)
				board.check_result(m_tdata, m_tuser, m_tlast);
		end
	end

	always @(posedge clk) begin
		beat <= beat + 1;
		if (stall_left == 0) begin
			stall_style <= $urandom_range(READY_ALWAYS, READY_MOSTLY);
			stall_left <= $urandom_range(16, 160);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
			READY_ALWAYS: m_tready <= 1'b1;
			READY_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
			READY_SPARSE: m_tready <= (beat % 4 == 0);
			default:      m_tready <= ($urandom_range(0, 4) != 0);
		endcase
	end

	task automatic send_cluster(input logic [IN_TDATA_W-1:0] item);
		int pause;
		s_tvalid <= 1'b1;
		s_tdata <= item;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			pause = $urandom_range(0, 6);
			if (pause > 0) begin
				s_tvalid <= 1'b0;
				repeat (pause) @(posedge clk);
			end
		end
	endtask

	// Holds the sender off until every expected result has arrived.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [CHUNK_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [1:0] mode, input logic en,
		input logic [CHUNK_W-1:0] chunk, input logic [POS_W-1:0] pos);
		cfg_write(REG_SAMPLE_MODE, CHUNK_W'(mode));
		cfg_write(REG_TRIGGER_ENABLE, CHUNK_W'(en));
		cfg_write(REG_TRIGGER_CHUNK, chunk);
		cfg_write(REG_TRIGGER_POSITION, CHUNK_W'(pos));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Trigger position that lands on the given cluster and event slot.
	function automatic logic [POS_W-1:0] aim_trigger(input int cluster, input int slot,
		input logic [1:0] mode);
		return POS_W'(7 * cluster + slot + ((mode == MODE_16) ? 7 : 0));
	endfunction

	function automatic logic [15:0] next_stamp(input logic [15:0] prev);
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return prev + 16'd7;
		else if (r < 70)
			return prev + 16'($urandom_range(0, 6));
		else if (r < 85)
			return prev + 16'($urandom_range(8, 40));
		else if (r < 95)
			return prev + 16'($urandom_range(41, 65535));
		return 16'($urandom);
	endfunction

	function automatic logic [111:0] random_events();
		logic [111:0] ev;
		logic [15:0] word;
		int r;
		r = $urandom_range(0, 19);
		word = 16'($urandom);
		for (int j = 0; j < EVENTS; j++)
			ev[16 * j +: 16] = (r == 0) ? 16'h0000 : (r == 1) ? 16'hffff :
				(r == 2) ? word : 16'($urandom);
		return ev;
	endfunction

	initial begin
		logic [15:0] ts;
		logic [1:0] mode;
		logic en;
		logic [CHUNK_W-1:0] chunk;
		logic [POS_W-1:0] pos;
		int r;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 16 probes: a position below one cluster puts the marker ahead of all
		// samples of the first cluster, which yields no pad despite its large gap.
		configure(MODE_16, 1'b1, '0, POS_W'(3));
		send_cluster({{7{16'h0000}}, 16'hffff});
		send_cluster({{7{16'hffff}}, 16'h0006});
		send_cluster({{7{16'ha5c3}}, 16'h000e});
		send_cluster({{7{16'h5a3c}}, 16'h000d});
		send_cluster({{7{16'h0001}}, 16'h000d});
		send_cluster({{7{16'h8000}}, 16'h0010});
		ts = 16'h0010;

		// 8 probes: marker after three samples, then the largest gap.
		drain();
		configure(MODE_8, 1'b1, board.chunk_idx, aim_trigger(board.cluster_idx, 6, MODE_8));
		send_cluster({16'h00ff, 16'hff00, 16'haaaa, 16'h5555, 16'hffff, 16'h0000,
			16'h1234, ts + 16'd7});
		send_cluster({random_events(), ts + 16'd6});
		send_cluster({random_events(), ts + 16'd15});
		ts = ts + 16'd15;

		// 4 probes: a slot below the offset clamps the marker to the front.
		drain();
		configure(2'd2, 1'b1, board.chunk_idx, aim_trigger(board.cluster_idx, 1, 2'd2));
		send_cluster({{7{16'h8421}}, ts + 16'd7});
		send_cluster({{7{16'h1248}}, ts + 16'd6});
		send_cluster({random_events(), ts + 16'd13});
		ts = ts + 16'd13;

		// Unused mode 3 with the trigger cluster out of range.
		drain();
		configure(2'd3, 1'b1, board.chunk_idx, '1);
		send_cluster({{7{16'hf0f0}}, ts + 16'd7});
		send_cluster({random_events(), ts + 16'd100});
		ts = ts + 16'd100;

		// Trigger armed for a chunk that is not current.
		drain();
		configure(MODE_16, 1'b1, '1, aim_trigger(board.cluster_idx, 0, MODE_16));
		send_cluster({random_events(), ts + 16'd7});
		send_cluster({random_events(), ts + 16'd8});
		ts = ts + 16'd8;

		for (int phase = 0; phase < 10; phase++) begin
			drain();
			mode = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
			en = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 9);
			chunk = (r < 7) ? board.chunk_idx : (r == 7) ? '0 : (r == 8) ? '1 :
				CHUNK_W'($urandom);
			r = $urandom_range(0, 9);
			if (r < 6)
				pos = aim_trigger($urandom_range(board.cluster_idx, CLUSTERS_PER_CHUNK - 1),
					$urandom_range(0, 6), mode);
			else if (r == 6)
				pos = '0;
			else if (r == 7)
				pos = '1;
			else if (r == 8)
				pos = POS_W'($urandom);
			else
				pos = aim_trigger(CLUSTERS_PER_CHUNK - 1, 6, mode);
			configure(mode, en, chunk, pos);
			for (int n = 0; n < 34; n++) begin
				if (phase == 5 && n == 17)
					drain();
				ts = next_stamp(ts);
				send_cluster({random_events(), ts});
			end
		end

		drain();
		if (board.pending() != 0)
			$display("%0t: %0d expected results never arrived", $time, board.pending());
		if (board.errors == 0 && board.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
